// ----- sv/output_voltage_window_classifier_top_defines.svh -----
// assertion macros used by the classifier top level
`ifndef OUTPUT_VOLTAGE_WINDOW_CLASSIFIER_TOP_DEFINES_SVH
`define OUTPUT_VOLTAGE_WINDOW_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define OVWC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ovwc assertion failed");

// next-cycle implication, checked outside reset
`define OVWC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ovwc assertion failed");

`endif

// ----- sv/ovwc_pkg.sv -----
// shared constants and types of the output voltage window classifier
package ovwc_pkg;

  localparam int WINDOW_DEF     = 10;
  localparam int DATA_W         = 8;
  localparam int LOAD_W         = 6;
  localparam int VERDICT_W      = 2;

  localparam int HOLDOFF_RESET  = 50;
  localparam int THRESHOLD_RESET = 20;
  localparam int SMALL_GAP      = 2;
  localparam int PULSE_N_LIMIT  = 7;
  localparam int PULSE_GAP_MIN  = 6;
  localparam int BATT_GAP_LIMIT = 6;

  localparam logic [VERDICT_W-1:0] VERDICT_NONE    = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_PULSE   = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_BATTERY = 2'd2;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic              valid;
    logic              gt;
    logic [DATA_W-1:0] val;
  } cell_out_t;

  typedef struct packed {
    logic clear;
    logic en;
  } acc_ctrl_t;

endpackage

// ----- sv/ovwc_sort_cell.sv -----
// one cell of the insertion sort chain
module ovwc_sort_cell
  import ovwc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] din,
  input  cell_out_t         left,
  input  logic [DATA_W-1:0] right_val,
  output cell_out_t         dout
);

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic              gt;

  // empty cells act as +inf so new values settle left of them
  assign gt = !valid_r || (din < val_r);

  always_comb begin
    valid_nxt = valid_r;
    val_nxt   = val_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctrl.insert && gt) begin
      if (left.gt) begin
        valid_nxt = left.valid;
        val_nxt   = left.val;
      end else begin
        valid_nxt = 1'b1;
        val_nxt   = din;
      end
    end else if (ctrl.shift) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign dout.valid = valid_r;
  assign dout.gt    = gt;
  assign dout.val   = val_r;

endmodule

// ----- sv/ovwc_gap_acc.sv -----
// gap statistics over adjacent sorted values
module ovwc_gap_acc
  import ovwc_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  acc_ctrl_t                         ctrl,
  input  logic [DATA_W-1:0]                 lo,
  input  logic [DATA_W-1:0]                 hi,
  output logic [$clog2(WINDOW+1)-1:0]       small_cnt,
  output logic [$clog2(WINDOW+1)-1:0]       small_sum,
  output logic [DATA_W-1:0]                 max_gap
);

  localparam int CW = $clog2(WINDOW + 1);

  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     s_r, s_nxt;
  logic [DATA_W-1:0] m_r, m_nxt;
  logic [DATA_W-1:0] gap;
  logic              gap_is_small;

  assign gap          = hi - lo;
  assign gap_is_small = gap < DATA_W'(SMALL_GAP);

  always_comb begin
    n_nxt = n_r;
    s_nxt = s_r;
    m_nxt = m_r;
    if (ctrl.clear) begin
      n_nxt = '0;
      s_nxt = '0;
      m_nxt = '0;
    end else if (ctrl.en) begin
      if (gap_is_small) begin
        n_nxt = n_r + CW'(1);
        s_nxt = s_r + CW'(gap[0]);
      end else if (gap > m_r) begin
        m_nxt = gap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
      s_r <= '0;
      m_r <= '0;
    end else begin
      n_r <= n_nxt;
      s_r <= s_nxt;
      m_r <= m_nxt;
    end
  end

  assign small_cnt = n_r;
  assign small_sum = s_r;
  assign max_gap   = m_r;

endmodule

// ----- sv/output_voltage_window_classifier_top.sv -----
// top level of the output voltage window classifier
// a holdoff item goes from the input transfer straight to the decide step, a
//   classified item first runs the insertion pass and then the gap scan
// one item in flight: no new input is taken before the decide step hands the
//   verdict to the result register; that step waits while the register is full
// reset: synchronous active-low rst_n clears the ring and write position,
//   loads holdoff with 50, threshold with 20 and clears the confirm count
module output_voltage_window_classifier_top
  import ovwc_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DATA_W-1:0]    in_sample,
  input  logic                 in_release_flag,
  input  logic [LOAD_W-1:0]    in_holdoff_load,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VERDICT_W-1:0] out_verdict,
  // configuration
  input  logic                 cfg_wr_en,
  input  logic [DATA_W-1:0]    cfg_wr_data
);

`include "output_voltage_window_classifier_top_defines.svh"

  localparam int IW   = $clog2(WINDOW);
  localparam int CW   = $clog2(WINDOW + 1);
  localparam int HALF = WINDOW / 2;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOAD   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  // control and architectural state
  logic [1:0]           state_r, state_nxt;
  logic [IW-1:0]        cnt_r, cnt_nxt;
  logic [IW-1:0]        wpos_r, wpos_nxt;
  logic [LOAD_W-1:0]    holdoff_r, holdoff_nxt;
  logic [1:0]           confirm_r, confirm_nxt;
  logic [DATA_W-1:0]    threshold_r;
  logic                 hold_r, hold_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [VERDICT_W-1:0] out_verdict_r, out_verdict_nxt;
  logic [DATA_W-1:0]    ring_r [WINDOW];

  // payload of the item in flight
  logic [DATA_W-1:0]    samp_r;
  logic                 rel_r;

  logic                 in_xfer;
  logic                 out_free;
  logic [LOAD_W-1:0]    hold_eff;
  logic [DATA_W-1:0]    ring_rd;
  logic                 load_last;

  cell_ctrl_t           cell_ctrl;
  cell_out_t            cell_q [WINDOW];
  acc_ctrl_t            acc_ctrl;
  logic [CW-1:0]        n_q, s_q;
  logic [DATA_W-1:0]    m_q;

  logic                 is_pulse, is_batt;
  logic [1:0]           confirm_inc;

  // one item in flight; the result register frees the input side
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // holdoff load applies before the countdown check
  assign hold_eff = (in_holdoff_load != '0) ? in_holdoff_load : holdoff_r;
  assign ring_rd  = ring_r[cnt_r];

  // last insertion cycle of the load pass
  assign load_last = (state_r == ST_LOAD) && (cnt_r == IW'(WINDOW - 1));

  // sort chain: cleared on transfer, fed one ring entry a cycle, then
  // shifted toward cell 0 so cells 0 and 1 carry all pairs but the top one
  assign cell_ctrl.clear  = in_xfer;
  assign cell_ctrl.insert = (state_r == ST_LOAD);
  assign cell_ctrl.shift  = (state_r == ST_SCAN);

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    cell_out_t         left_in;
    logic [DATA_W-1:0] right_in;

    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid
      assign left_in = cell_q[g-1];
    end

    if (g == WINDOW - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_inner
      assign right_in = cell_q[g+1].val;
    end

    ovwc_sort_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (cell_ctrl),
      .din       (ring_rd),
      .left      (left_in),
      .right_val (right_in),
      .dout      (cell_q[g])
    );
  end

  // scan step zero is the pair at sorted indices 0 and 1, which is skipped
  assign acc_ctrl.clear = in_xfer;
  assign acc_ctrl.en    = (state_r == ST_SCAN) && (cnt_r != '0);

  ovwc_gap_acc #(
    .WINDOW (WINDOW)
  ) u_gap_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (acc_ctrl),
    .lo        (cell_q[0].val),
    .hi        (cell_q[1].val),
    .small_cnt (n_q),
    .small_sum (s_q),
    .max_gap   (m_q)
  );

  // verdict rules
  assign is_pulse = (n_q > CW'(HALF)) && (n_q < CW'(PULSE_N_LIMIT)) &&
                    (m_q > DATA_W'(PULSE_GAP_MIN)) && (s_q < CW'(HALF));
  assign is_batt  = (s_q < CW'(WINDOW)) && (m_q < DATA_W'(BATT_GAP_LIMIT)) &&
                    (samp_r > threshold_r);
  assign confirm_inc = confirm_r + 2'd1;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    wpos_nxt        = wpos_r;
    holdoff_nxt     = holdoff_r;
    confirm_nxt     = confirm_r;
    hold_nxt        = hold_r;
    out_valid_nxt   = out_valid_r;
    out_verdict_nxt = out_verdict_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          wpos_nxt = (wpos_r == IW'(WINDOW - 1)) ? '0 : wpos_r + IW'(1);
          cnt_nxt  = '0;
          if (hold_eff != '0) begin
            // countdown step, answer undecided without sorting
            holdoff_nxt = hold_eff - LOAD_W'(1);
            hold_nxt    = 1'b1;
            state_nxt   = ST_DECIDE;
          end else begin
            holdoff_nxt = hold_eff;
            hold_nxt    = 1'b0;
            state_nxt   = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (cnt_r == IW'(WINDOW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      ST_SCAN: begin
        if (cnt_r == IW'(WINDOW - 3)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DECIDE;
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      ST_DECIDE: begin
        // wait here until the result register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (hold_r) begin
            out_verdict_nxt = VERDICT_NONE;
          end else if (is_pulse) begin
            holdoff_nxt     = LOAD_W'(WINDOW);
            out_verdict_nxt = VERDICT_PULSE;
          end else if (is_batt) begin
            holdoff_nxt = LOAD_W'(WINDOW);
            if (rel_r || (confirm_inc > 2'd1)) begin
              confirm_nxt     = 2'd0;
              out_verdict_nxt = VERDICT_BATTERY;
            end else begin
              confirm_nxt     = confirm_inc;
              out_verdict_nxt = VERDICT_NONE;
            end
          end else begin
            confirm_nxt     = 2'd0;
            out_verdict_nxt = VERDICT_NONE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      wpos_r      <= '0;
      holdoff_r   <= LOAD_W'(HOLDOFF_RESET);
      confirm_r   <= 2'd0;
      threshold_r <= DATA_W'(THRESHOLD_RESET);
      hold_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wpos_r      <= wpos_nxt;
      holdoff_r   <= holdoff_nxt;
      confirm_r   <= confirm_nxt;
      hold_r      <= hold_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        threshold_r <= cfg_wr_data;
      end
    end
  end

  // sample ring, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring_r[i] <= '0;
      end
    end else if (in_xfer) begin
      ring_r[wpos_r] <= in_sample;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_verdict_r <= out_verdict_nxt;
    if (in_xfer) begin
      samp_r <= in_sample;
      rel_r  <= in_release_flag;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  // a running holdoff sends the transfer straight to the decide step
  `OVWC_ASSERT_NXT(a_holdoff_skip, in_xfer && (hold_eff != '0), (state_r == ST_DECIDE) && hold_r)
  // the scan never runs past the last examined pair
  `OVWC_ASSERT_IMP(a_scan_range, state_r == ST_SCAN, cnt_r <= IW'(WINDOW - 3))
  // after the last insertion every cell holds a sample
  `OVWC_ASSERT_IMP(a_cells_full, state_r == ST_SCAN, cell_q[0].valid && cell_q[WINDOW-1].valid)
  // the head of the chain is in order once loading ends
  `OVWC_ASSERT_NXT(a_head_sorted, load_last, cell_q[0].val <= cell_q[1].val)

endmodule

// ----- tb/ovwc_verdict_checker.sv -----
`timescale 1ns / 1ps
// transfer monitor, verdict predictor and comparison for the window classifier
module ovwc_verdict_checker
  import ovwc_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [DATA_W-1:0]    in_sample,
  input  logic                 in_release_flag,
  input  logic [LOAD_W-1:0]    in_holdoff_load,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [VERDICT_W-1:0] out_verdict,
  input  logic                 cfg_wr_en,
  input  logic [DATA_W-1:0]    cfg_wr_data,
  output int                   pending_results,
  output int                   mismatch_count
);

  // predicted copy of the classifier state
  logic [DATA_W-1:0]    sample_ring [WINDOW];
  int                   write_pos;
  logic [LOAD_W-1:0]    holdoff_left;
  logic [1:0]           confirm_count;
  logic [DATA_W-1:0]    short_level;

  logic [VERDICT_W-1:0] expected_verdicts [$];

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic reset_model();
    foreach (sample_ring[i]) sample_ring[i] = '0;
    write_pos     = 0;
    holdoff_left  = LOAD_W'(HOLDOFF_RESET);
    confirm_count = '0;
    short_level   = DATA_W'(THRESHOLD_RESET);
  endtask

  // advances the predicted state by one sample and returns its verdict
  function automatic logic [VERDICT_W-1:0] classify_sample(
    input logic [DATA_W-1:0] smp,
    input logic              rel,
    input logic [LOAD_W-1:0] load
  );
    logic [DATA_W-1:0] sorted [WINDOW];
    logic [DATA_W-1:0] key;
    int j, n_small, sum_small, max_gap, gap;

    if (load != '0) holdoff_left = load;
    if (write_pos >= WINDOW) write_pos = 0;
    sample_ring[write_pos] = smp;
    write_pos++;
    if (write_pos >= WINDOW) write_pos = 0;

    if (holdoff_left != '0) begin
      holdoff_left--;
      return VERDICT_NONE;
    end

    sorted = sample_ring;
    for (int i = 1; i < WINDOW; i++) begin
      key = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > key) begin
        sorted[j+1] = sorted[j];
        j--;
      end
      sorted[j+1] = key;
    end

    // gaps of the inner part of the sorted window only
    n_small = 0;
    sum_small = 0;
    max_gap = 0;
    for (int i = 1; i < WINDOW - 2; i++) begin
      gap = int'(sorted[i+1]) - int'(sorted[i]);
      if (gap < SMALL_GAP) begin
        n_small++;
        sum_small += gap;
      end else if (gap > max_gap) begin
        max_gap = gap;
      end
    end

    if (n_small > WINDOW / 2 && n_small < PULSE_N_LIMIT && max_gap > PULSE_GAP_MIN &&
        sum_small < WINDOW / 2) begin
      holdoff_left = LOAD_W'(WINDOW);
      return VERDICT_PULSE;
    end
    if (sum_small < WINDOW && max_gap < BATT_GAP_LIMIT && smp > short_level) begin
      holdoff_left = LOAD_W'(WINDOW);
      confirm_count = confirm_count + 2'd1;
      if (rel || confirm_count > 2'd1) begin
        confirm_count = '0;
        return VERDICT_BATTERY;
      end
      return VERDICT_NONE;
    end
    confirm_count = '0;
    return VERDICT_NONE;
  endfunction

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
    reset_model();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
      expected_verdicts.delete();
    end else begin
      if (cfg_wr_en) short_level = cfg_wr_data;
      // results first, so a stray result never meets this cycle's expectation
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("result transfer with no expectation, verdict %0d",
                                    out_verdict));
        end else if (out_verdict !== expected_verdicts[0]) begin
          report_mismatch($sformatf("verdict mismatch: got %0d, want %0d",
                                    out_verdict, expected_verdicts[0]));
          void'(expected_verdicts.pop_front());
        end else begin
          void'(expected_verdicts.pop_front());
        end
      end
      if (in_valid && in_ready)
        expected_verdicts.push_back(classify_sample(in_sample, in_release_flag,
                                                    in_holdoff_load));
    end
    pending_results = expected_verdicts.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// stimulus, clock, reset and final verdict for the window classifier testbench
module testbench;
  import ovwc_pkg::*;

  localparam int WINDOW          = WINDOW_DEF;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 300;

  // shapes of random sample sequences
  typedef enum int {
    SEQ_STEADY,
    SEQ_PULSING,
    SEQ_NOISE,
    SEQ_OUTLIER
  } seq_kind_t;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_ready;
  logic [DATA_W-1:0]    in_sample       = '0;
  logic                 in_release_flag = 1'b0;
  logic [LOAD_W-1:0]    in_holdoff_load = '0;
  logic                 out_valid;
  logic                 out_ready       = 1'b0;
  logic [VERDICT_W-1:0] out_verdict;
  logic                 cfg_wr_en       = 1'b0;
  logic [DATA_W-1:0]    cfg_wr_data     = '0;

  // per-cycle idle chances in percent, changed per phase
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  int pending_results;
  int mismatch_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  output_voltage_window_classifier_top #(
    .WINDOW(WINDOW)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_release_flag(in_release_flag),
    .in_holdoff_load(in_holdoff_load),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_verdict    (out_verdict),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  ovwc_verdict_checker #(
    .WINDOW(WINDOW)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_release_flag(in_release_flag),
    .in_holdoff_load(in_holdoff_load),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_verdict    (out_verdict),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .pending_results(pending_results),
    .mismatch_count (mismatch_count)
  );

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // one input transfer, then a random number of idle cycles on the sender side
  task automatic send_sample(
    input logic [DATA_W-1:0] smp,
    input logic              rel,
    input logic [LOAD_W-1:0] load
  );
    in_valid        <= 1'b1;
    in_sample       <= smp;
    in_release_flag <= rel;
    in_holdoff_load <= load;
    do @(posedge clk); while (!in_ready);
    // valid drops only in a later step than the one it was raised for
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // stop sending and wait until every expected verdict has come back;
  // read at the falling edge so the checker's count has settled
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
  endtask

  // the threshold is written only with the block idle
  task automatic write_threshold(input logic [DATA_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // holdoff load: mostly none, sometimes short, rarely the full range
  function automatic logic [LOAD_W-1:0] pick_load();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return '0;
    if (r < 97) return LOAD_W'($urandom_range(1, 3));
    return LOAD_W'($urandom_range(1, 63));
  endfunction

  // bursts of steady, two-level, noisy and outlier-ridden sample sequences
  task automatic run_random(input int count);
    int        sent, burst_len, base, high_level;
    seq_kind_t kind;
    logic      rel;
    logic [DATA_W-1:0] smp;

    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 99)) inside
        [0:39]:  kind = SEQ_STEADY;
        [40:69]: kind = SEQ_PULSING;
        [70:84]: kind = SEQ_NOISE;
        default: kind = SEQ_OUTLIER;
      endcase
      burst_len = $urandom_range(12, 30);
      if (kind == SEQ_PULSING) base = $urandom_range(0, 200);
      else base = $urandom_range(0, 254);
      // the jump between levels lands in the inner gaps of the sorted window
      high_level = base + $urandom_range(7, 55);
      for (int k = 0; k < burst_len && sent < count; k++) begin
        rel = ($urandom_range(0, 99) < 30);
        case (kind)
          SEQ_STEADY:  smp = DATA_W'(base + $urandom_range(0, 1));
          SEQ_PULSING: begin
            smp = (k % 2 == 1) ? DATA_W'(high_level) : DATA_W'(base);
            if ($urandom_range(0, 99) < 15) smp = smp + 8'd1;
            rel = ($urandom_range(0, 1) == 1);
          end
          SEQ_NOISE:   begin
            smp = DATA_W'($urandom_range(0, 255));
            rel = ($urandom_range(0, 1) == 1);
          end
          default: begin
            if ($urandom_range(0, 99) < 20) smp = DATA_W'($urandom_range(0, 255));
            else smp = DATA_W'(base + $urandom_range(0, 1));
          end
        endcase
        send_sample(smp, rel, pick_load());
        sent++;
      end
    end
  endtask

  initial begin
    logic [DATA_W-1:0] level;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: load extremes, a pulsing verdict from a lone spike pair,
    // a battery verdict on release, confirm count started, ring wrap
    send_sample(8'd255, 1'b1, 6'd63);
    send_sample(8'd0, 1'b0, 6'd1);
    send_sample(8'd30, 1'b0, 6'd0);
    repeat (10) send_sample(8'd30, 1'b0, 6'd0);
    send_sample(8'd30, 1'b1, 6'd0);
    repeat (10) send_sample(8'd30, 1'b0, 6'd0);
    send_sample(8'd31, 1'b0, 6'd0);

    // random phases, each with its own threshold and a cycled idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 58; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 58; end
        default: begin tx_idle_pct = 28; rx_stall_pct = 28; end
      endcase
      case (p)
        0:       level = DATA_W'(THRESHOLD_RESET);
        1:       level = 8'd0;
        2:       level = 8'd255;
        3:       level = DATA_W'($urandom_range(21, 120));
        4:       level = 8'd254;
        default: level = DATA_W'($urandom_range(0, 255));
      endcase
      write_threshold(level);
      run_random(ITEMS_PER_PHASE);
    end

    // let any late or extra result show up before the verdict
    wait_drained();
    repeat (2 * WINDOW + 5) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // generous run limit, several times the slowest correct run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
